@@ rtl/rvr_pkg.sv @@
// Shared constants, tables and latency helpers for the rotation pipeline.
// No dependencies; all other files but rvr_delay refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rvr_pkg;

  // Internal fraction bits of the unit axis, sin, cos and angle
  localparam int IFRAC = 30;

  // Angle constants and the CORDIC gain, Q30
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;

  // Arctangent of 2^-i, Q30
  localparam logic [29:0] ATAN_Q30 [30] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  // Field widths
  localparam int COMP_W  = 32;
  localparam int ANGLE_W = 19;

  // Stage counts of the axis normaliser and the cross-product datapath
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int NORM_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int CROSS_LAT  = 6;

  // Number of 2*pi multiples (as a power of two) needed to fold the angle
  function automatic int ang_wraps(int frac_bits);
    longint lim;
    int     kb;
    lim = (longint'(1) << (ANGLE_W - 1 + IFRAC - frac_bits)) + longint'(PI_Q30);
    kb  = 0;
    for (int k = 0; k < 16; k++) begin
      if ((longint'(TWO_PI_Q30) << k) <= lim) kb = k + 1;
    end
    return kb;
  endfunction

  // Latency of the sin/cos unit in register stages
  function automatic int sc_lat(int frac_bits, int steps);
    return ang_wraps(frac_bits) + steps + 4;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rvr_delay.sv @@
// Enabled shift line that aligns payload with the pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rvr_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // Advance the line on every pipeline step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/rvr_norm.sv @@
// Axis normaliser: scale, sum of squares, pipelined square root and divide.
// Depends on rvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvr_norm (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [2:0][31:0] axis_i,
  output logic      [2:0][31:0] unit_o,  // Q30 unit axis, signed
  output logic                  zero_o
);

  localparam int SQRT_STEPS = rvr_pkg::SQRT_STEPS;
  localparam int DIV_STEPS  = rvr_pkg::DIV_STEPS;

  typedef struct packed {
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [63:0]      rad;
    logic [2:0][31:0] us;
    logic [2:0]       neg;
    logic             zero;
  } sqrt_st_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][30:0] quo;
    logic [2:0]       nb;
    logic [31:0]      len;
    logic [2:0]       neg;
    logic             zero;
  } div_st_t;

  // Magnitudes and the normalising shift
  logic [2:0][31:0] ua_d;
  logic [31:0]      mx_d;
  logic [4:0]       msb_d;
  logic [4:0]       sh_d;

  always_comb begin
    mx_d  = '0;
    msb_d = '0;
    for (int i = 0; i < 3; i++) begin
      ua_d[i] = axis_i[i][31] ? (32'd0 - axis_i[i]) : axis_i[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (ua_d[i] > mx_d) mx_d = ua_d[i];
    end
    for (int b = 0; b < 32; b++) begin
      if (mx_d[b]) msb_d = 5'(b);
    end
    sh_d = (msb_d >= 5'd30) ? 5'd0 : 5'd30 - msb_d;
  end

  logic [2:0][31:0] n1_ua_q;
  logic [2:0]       n1_neg_q;
  logic [4:0]       n1_sh_q;
  logic             n1_zero_q;
  logic [2:0][31:0] n2_us_q;
  logic [2:0]       n2_neg_q;
  logic             n2_zero_q;
  logic [2:0][63:0] n3_sq_q;
  logic [2:0][31:0] n3_us_q;
  logic [2:0]       n3_neg_q;
  logic             n3_zero_q;
  sqrt_st_t         n4_q;

  // Register magnitudes, shift them up, square them, sum them
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_ua_q   <= ua_d;
      n1_neg_q  <= {axis_i[2][31], axis_i[1][31], axis_i[0][31]};
      n1_sh_q   <= sh_d;
      n1_zero_q <= (mx_d == '0);
      for (int i = 0; i < 3; i++) begin
        n2_us_q[i] <= n1_ua_q[i] << n1_sh_q;
        n3_sq_q[i] <= 64'(n2_us_q[i]) * 64'(n2_us_q[i]);
      end
      n2_neg_q    <= n1_neg_q;
      n2_zero_q   <= n1_zero_q;
      n3_us_q     <= n2_us_q;
      n3_neg_q    <= n2_neg_q;
      n3_zero_q   <= n2_zero_q;
      n4_q.rem    <= '0;
      n4_q.root   <= '0;
      n4_q.rad    <= n3_sq_q[0] + n3_sq_q[1] + n3_sq_q[2];
      n4_q.us     <= n3_us_q;
      n4_q.neg    <= n3_neg_q;
      n4_q.zero   <= n3_zero_q;
    end
  end

  // Square root, one result bit per stage
  sqrt_st_t sq_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    sqrt_st_t   st_in;
    logic [35:0] cat;
    logic [35:0] trial;
    if (j == 0) begin : g_first
      assign st_in = n4_q;
    end else begin : g_next
      assign st_in = sq_q[j-1];
    end
    assign cat   = {st_in.rem, st_in.rad[63:62]};
    assign trial = {2'b00, st_in.root, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[j].rad  <= st_in.rad << 2;
        sq_q[j].us   <= st_in.us;
        sq_q[j].neg  <= st_in.neg;
        sq_q[j].zero <= st_in.zero;
        if (cat >= trial) begin
          sq_q[j].rem  <= 34'(cat - trial);
          sq_q[j].root <= {st_in.root[30:0], 1'b1};
        end else begin
          sq_q[j].rem  <= cat[33:0];
          sq_q[j].root <= {st_in.root[30:0], 1'b0};
        end
      end
    end
  end

  // Seed the divider: numerator is the scaled magnitude times 2^30
  div_st_t dv_init;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = {1'b0, sq_q[SQRT_STEPS-1].us[i][31:1]};
      dv_init.quo[i] = '0;
      dv_init.nb[i]  = sq_q[SQRT_STEPS-1].us[i][0];
    end
    dv_init.len  = sq_q[SQRT_STEPS-1].root;
    dv_init.neg  = sq_q[SQRT_STEPS-1].neg;
    dv_init.zero = sq_q[SQRT_STEPS-1].zero;
  end

  // Restoring divide, one quotient bit per stage for all three components
  div_st_t dv_q [DIV_STEPS];

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    div_st_t          st_in;
    logic [2:0][32:0] cat;
    logic [2:0]       ge;
    if (t == 0) begin : g_first
      assign st_in = dv_init;
    end else begin : g_next
      assign st_in = dv_q[t-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cat[i] = {st_in.rem[i], st_in.nb[i]};
        ge[i]  = (cat[i] >= {1'b0, st_in.len});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_q[t].rem[i] <= ge[i] ? 32'(cat[i] - {1'b0, st_in.len}) : cat[i][31:0];
          dv_q[t].quo[i] <= {st_in.quo[i][29:0], ge[i]};
        end
        dv_q[t].nb   <= '0;
        dv_q[t].len  <= st_in.len;
        dv_q[t].neg  <= st_in.neg;
        dv_q[t].zero <= st_in.zero;
      end
    end
  end

  // Apply the signs
  logic [2:0][31:0] unit_q;
  logic             zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        unit_q[i] <= dv_q[DIV_STEPS-1].neg[i] ? (32'd0 - {1'b0, dv_q[DIV_STEPS-1].quo[i]})
                                               : {1'b0, dv_q[DIV_STEPS-1].quo[i]};
      end
      zero_q <= dv_q[DIV_STEPS-1].zero;
    end
  end

  assign unit_o = unit_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

@@ rtl/rvr_sincos.sv @@
// Angle range reduction and pipelined CORDIC giving sin and 1 - cos in Q30.
// Depends on rvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvr_sincos #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [18:0]       angle_i,
  output logic signed [33:0]     sin_o,
  output logic signed [33:0]     omc_o
);

  localparam int KB = rvr_pkg::ang_wraps(FRAC_BITS);
  localparam int AW = 34 + KB;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } cord_st_t;

  // Offset the angle so it is non-negative; pi is added so the wrap lands in [-pi, pi)
  logic [AW-1:0] ang_ext;
  logic [AW-1:0] ang_off;

  assign ang_ext = {{(AW - 19){angle_i[18]}}, angle_i} << (rvr_pkg::IFRAC - FRAC_BITS);
  assign ang_off = ang_ext + AW'(rvr_pkg::PI_Q30) + (AW'(rvr_pkg::TWO_PI_Q30) << KB);

  logic [AW-1:0] red_q [KB+2];

  // Reduce modulo 2*pi, one multiple per stage from the largest down
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q[0] <= ang_off;
      for (int j = 0; j <= KB; j++) begin
        if (red_q[j] >= (AW'(rvr_pkg::TWO_PI_Q30) << (KB - j))) begin
          red_q[j+1] <= red_q[j] - (AW'(rvr_pkg::TWO_PI_Q30) << (KB - j));
        end else begin
          red_q[j+1] <= red_q[j];
        end
      end
    end
  end

  // Fold into the right half plane and remember to negate
  logic signed [33:0] th_d;
  logic signed [33:0] pi_s;
  logic signed [33:0] half_s;
  cord_st_t           fold_d;

  assign pi_s   = $signed({2'b00, rvr_pkg::PI_Q30});
  assign half_s = $signed({3'b000, rvr_pkg::HALF_PI_Q30});
  assign th_d   = $signed({1'b0, red_q[KB+1][32:0]}) - pi_s;

  always_comb begin
    fold_d.x   = $signed({4'b0000, rvr_pkg::GAIN_Q30});
    fold_d.y   = '0;
    fold_d.z   = th_d;
    fold_d.neg = 1'b0;
    if (th_d > half_s) begin
      fold_d.z   = th_d - pi_s;
      fold_d.neg = 1'b1;
    end else if (th_d < -half_s) begin
      fold_d.z   = th_d + pi_s;
      fold_d.neg = 1'b1;
    end
  end

  cord_st_t cs_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q[0] <= fold_d;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
    logic signed [33:0] atn;
    assign atn = $signed({4'b0000, rvr_pkg::ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[i+1].neg <= cs_q[i].neg;
        if (cs_q[i].z >= 0) begin
          cs_q[i+1].x <= cs_q[i].x - (cs_q[i].y >>> i);
          cs_q[i+1].y <= cs_q[i].y + (cs_q[i].x >>> i);
          cs_q[i+1].z <= cs_q[i].z - atn;
        end else begin
          cs_q[i+1].x <= cs_q[i].x + (cs_q[i].y >>> i);
          cs_q[i+1].y <= cs_q[i].y - (cs_q[i].x >>> i);
          cs_q[i+1].z <= cs_q[i].z + atn;
        end
      end
    end
  end

  // Undo the fold and form 1 - cos
  logic signed [33:0] sin_q;
  logic signed [33:0] omc_q;
  logic signed [33:0] cos_d;
  logic signed [33:0] one_s;

  assign one_s = 34'sd1 <<< rvr_pkg::IFRAC;
  assign cos_d = cs_q[CORDIC_STEPS].neg ? -cs_q[CORDIC_STEPS].x : cs_q[CORDIC_STEPS].x;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= cs_q[CORDIC_STEPS].neg ? -cs_q[CORDIC_STEPS].y : cs_q[CORDIC_STEPS].y;
      omc_q <= one_s - cos_d;
    end
  end

  assign sin_o = sin_q;
  assign omc_o = omc_q;

endmodule

`default_nettype wire

@@ rtl/rvr_cross.sv @@
// Two cross products, the sin and 1 - cos terms, final sum and saturation.
// Depends on rvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvr_cross (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [2:0][31:0]   unit_i,
  input  wire logic [2:0][31:0]   vec_i,
  input  wire logic signed [33:0] sin_i,
  input  wire logic signed [33:0] omc_i,
  input  wire logic               zero_i,
  output logic      [2:0][31:0]   rot_o,
  output logic                    zero_o,
  output logic                    sat_o
);

  localparam int J1 [3] = '{1, 2, 0};
  localparam int J2 [3] = '{2, 0, 1};
  localparam logic signed [66:0] RND = 67'sd1 <<< (rvr_pkg::IFRAC - 1);

  logic signed [33:0] c1_s_q, c2_s_q, c3_s_q, c4_s_q;
  logic signed [33:0] c1_o_q, c2_o_q, c3_o_q, c4_o_q;
  logic [2:0][31:0]   c1_e_q, c2_e_q, c1_v_q, c2_v_q, c3_v_q, c4_v_q, c5_v_q;
  logic [4:0]         zero_q;
  logic signed [63:0] c1_pp_q [3];
  logic signed [63:0] c1_pn_q [3];
  logic signed [33:0] c2_k_q  [3];
  logic signed [33:0] c3_k_q  [3];
  logic signed [33:0] c4_k_q  [3];
  logic signed [65:0] c3_pp_q [3];
  logic signed [65:0] c3_pn_q [3];
  logic signed [33:0] c4_w_q  [3];
  logic signed [67:0] c5_a_q  [3];
  logic signed [67:0] c5_b_q  [3];

  logic signed [66:0] dk_d [3];
  logic signed [66:0] dw_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dk_d[i] = 67'(c1_pp_q[i]) - 67'(c1_pn_q[i]) + RND;
      dw_d[i] = 67'(c3_pp_q[i]) - 67'(c3_pn_q[i]) + RND;
    end
  end

  // First cross product, round, second cross product, round, scale
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        c1_pp_q[i] <= $signed(unit_i[J1[i]]) * $signed(vec_i[J2[i]]);
        c1_pn_q[i] <= $signed(unit_i[J2[i]]) * $signed(vec_i[J1[i]]);
        c2_k_q[i]  <= 34'(dk_d[i] >>> rvr_pkg::IFRAC);
        c3_k_q[i]  <= c2_k_q[i];
        c3_pp_q[i] <= $signed(c2_e_q[J1[i]]) * c2_k_q[J2[i]];
        c3_pn_q[i] <= $signed(c2_e_q[J2[i]]) * c2_k_q[J1[i]];
        c4_k_q[i]  <= c3_k_q[i];
        c4_w_q[i]  <= 34'(dw_d[i] >>> rvr_pkg::IFRAC);
        c5_a_q[i]  <= c4_s_q * c4_k_q[i];
        c5_b_q[i]  <= c4_o_q * c4_w_q[i];
      end
      c1_e_q <= unit_i;
      c2_e_q <= c1_e_q;
      c1_v_q <= vec_i;
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
      c4_v_q <= c3_v_q;
      c5_v_q <= c4_v_q;
      c1_s_q <= sin_i;
      c2_s_q <= c1_s_q;
      c3_s_q <= c2_s_q;
      c4_s_q <= c3_s_q;
      c1_o_q <= omc_i;
      c2_o_q <= c1_o_q;
      c3_o_q <= c2_o_q;
      c4_o_q <= c3_o_q;
      zero_q <= {zero_q[3:0], zero_i};
    end
  end

  // Sum, clip to the 32-bit range, or pass the vector for a zero axis
  logic signed [67:0] ra_d [3];
  logic signed [67:0] rb_d [3];
  logic signed [39:0] sum_d [3];
  logic [2:0][31:0]   rot_d;
  logic [2:0]         clip_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra_d[i]   = (c5_a_q[i] + 68'(RND)) >>> rvr_pkg::IFRAC;
      rb_d[i]   = (c5_b_q[i] + 68'(RND)) >>> rvr_pkg::IFRAC;
      sum_d[i]  = 40'($signed(c5_v_q[i])) + 40'(ra_d[i]) + 40'(rb_d[i]);
      clip_d[i] = 1'b0;
      rot_d[i]  = sum_d[i][31:0];
      if (zero_q[4]) begin
        rot_d[i] = c5_v_q[i];
      end else if (sum_d[i] > 40'sd2147483647) begin
        rot_d[i]  = 32'h7fff_ffff;
        clip_d[i] = 1'b1;
      end else if (sum_d[i] < -40'sd2147483648) begin
        rot_d[i]  = 32'h8000_0000;
        clip_d[i] = 1'b1;
      end
    end
  end

  logic [2:0][31:0] rot_q;
  logic             zo_q;
  logic             sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
      zo_q  <= zero_q[4];
      sat_q <= |clip_d;
    end
  end

  assign rot_o  = rot_q;
  assign zero_o = zo_q;
  assign sat_o  = sat_q;

endmodule

`default_nettype wire

@@ rtl/rodrigues_vector_rotation.sv @@
// Top level: streaming ports, valid chain, alignment and output skid stage.
// Depends on rvr_pkg, rvr_delay, rvr_norm, rvr_sincos and rvr_cross.
//
//   channel  | direction | tdata                                  | tuser
//   s_axis   | in        | vec_x,vec_y,vec_z,axis_x,axis_y,axis_z,| -
//            |           | angle (216 bits, zero padded)          |
//   m_axis   | out       | rot_x, rot_y, rot_z (96 bits)          | axis_zero, saturated
//
// One request is taken per clock while the skid stage is empty. Each passes 75
// register stages (68 for the axis normaliser, 6 for the cross product terms, 1
// output); its result then waits in the output register until it is taken.
// The sin/cos unit runs beside the axis path.
// Reset clears the valid chain and the output and skid flags only.
// A stalled output parks one result in the skid stage; the pipeline then holds.
`timescale 1ns / 1ps
`default_nettype none

module rodrigues_vector_rotation #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // vec_x[31:0], vec_y[63:32], vec_z[95:64], axis_x[127:96], axis_y[159:128],
  // axis_z[191:160], angle[210:192], zero pad [215:211]
  input  wire logic [215:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rot_x[31:0], rot_y[63:32], rot_z[95:64]
  output logic [95:0]       m_axis_tdata,
  // axis_zero[0], saturated[1]
  output logic [1:0]        m_axis_tuser
);

  localparam int SC_LAT    = rvr_pkg::sc_lat(FRAC_BITS, CORDIC_STEPS);
  localparam int TOTAL_LAT = rvr_pkg::NORM_LAT + rvr_pkg::CROSS_LAT;

  logic pipe_en;
  logic in_acc;
  logic skid_vld_q;

  assign pipe_en       = !skid_vld_q;
  assign s_axis_tready = pipe_en;
  assign in_acc        = s_axis_tvalid && pipe_en;

  // Unpack the request
  logic [2:0][31:0] vec_in;
  logic [2:0][31:0] axis_in;
  logic [18:0]      angle_in;

  assign vec_in   = s_axis_tdata[95:0];
  assign axis_in  = s_axis_tdata[191:96];
  assign angle_in = s_axis_tdata[210:192];

  // Valid chain alongside the data
  logic [TOTAL_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], in_acc};
    end
  end

  logic [2:0][31:0]   unit;
  logic               zero;
  logic signed [33:0] sin_raw, omc_raw;
  logic [67:0]        sc_al;
  logic [95:0]        vec_al;

  rvr_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .axis_i (axis_in),
    .unit_o (unit),
    .zero_o (zero)
  );

  rvr_sincos #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .angle_i (angle_in),
    .sin_o   (sin_raw),
    .omc_o   (omc_raw)
  );

  // Align sin/cos and the vector with the unit axis
  rvr_delay #(
    .WIDTH (68),
    .DEPTH (rvr_pkg::NORM_LAT - SC_LAT)
  ) u_sc_dly (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   ({sin_raw, omc_raw}),
    .q_o   (sc_al)
  );

  rvr_delay #(
    .WIDTH (96),
    .DEPTH (rvr_pkg::NORM_LAT)
  ) u_vec_dly (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .d_i   (vec_in),
    .q_o   (vec_al)
  );

  logic [2:0][31:0] rot;
  logic             rot_zero;
  logic             rot_sat;

  rvr_cross u_cross (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .unit_i (unit),
    .vec_i  (vec_al),
    .sin_i  ($signed(sc_al[67:34])),
    .omc_i  ($signed(sc_al[33:0])),
    .zero_i (zero),
    .rot_o  (rot),
    .zero_o (rot_zero),
    .sat_o  (rot_sat)
  );

  // Output register and skid stage
  logic        out_vld_q;
  logic [97:0] out_q;
  logic [97:0] skid_q;
  logic        take;
  logic        pipe_out;

  assign take     = out_vld_q && m_axis_tready;
  assign pipe_out = pipe_en && vld_q[TOTAL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) skid_vld_q <= 1'b0;
    end else if (pipe_out) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  // Move payload into the output or park it in the skid stage
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) out_q <= skid_q;
    end else if (pipe_out) begin
      if (!out_vld_q || take) begin
        out_q <= {rot_sat, rot_zero, rot};
      end else begin
        skid_q <= {rot_sat, rot_zero, rot};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q[95:0];
  assign m_axis_tuser  = out_q[97:96];

endmodule

`default_nettype wire

@@ verif/tb_rodrigues_vector_rotation.sv @@
// Self-checking testbench for rodrigues_vector_rotation: directed and random requests,
// random idling on both sides, and a bit-exact predictor held in a small scoreboard class.
// Depends on rvr_pkg and the rodrigues_vector_rotation top level.
`timescale 1ns / 1ps

module tb_rodrigues_vector_rotation;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int IFRAC        = rvr_pkg::IFRAC;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [31:0] rot_x;
    logic [31:0] rot_y;
    logic [31:0] rot_z;
    logic        axis_zero;
    logic        saturated;
  } rotation_t;

  // Rotation predictor and queue of expected rotations
  class rotation_scoreboard;
    rotation_t pending_q[$];
    int        mismatches;

    function automatic longint rnd30(longint p);
      return (p + (longint'(1) <<< (IFRAC - 1))) >>> IFRAC;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic void sin_cos(longint th, output longint s, output longint c);
      longint x, y, t, r, pi, half_pi, two_pi;
      bit     flip;
      pi      = longint'(rvr_pkg::PI_Q30);
      half_pi = longint'(rvr_pkg::HALF_PI_Q30);
      two_pi  = longint'(rvr_pkg::TWO_PI_Q30);
      x       = longint'(rvr_pkg::GAIN_Q30);
      y       = 0;
      flip    = 0;
      // Fold into [-pi, pi), then into the CORDIC convergence range
      r = (th + pi) % two_pi;
      if (r < 0) r = r + two_pi;
      th = r - pi;
      if (th > half_pi) begin
        th   = th - pi;
        flip = 1;
      end else if (th < -half_pi) begin
        th   = th + pi;
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
        if (th >= 0) begin
          t  = x - (y >>> i);
          y  = y + (x >>> i);
          th = th - longint'(rvr_pkg::ATAN_Q30[i]);
        end else begin
          t  = x + (y >>> i);
          y  = y - (x >>> i);
          th = th + longint'(rvr_pkg::ATAN_Q30[i]);
        end
        x = t;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function automatic rotation_t rotate(logic [215:0] d);
      rotation_t       res;
      longint          v[3], a[3], e[3], k[3], w[3], r[3];
      longint unsigned ua[3], m, sum, len;
      longint          s, c, omc, th;
      int              sh;
      m   = 0;
      sum = 0;
      sh  = 0;
      for (int i = 0; i < 3; i++) begin
        v[i]  = longint'($signed(d[32*i +: 32]));
        a[i]  = longint'($signed(d[96 + 32*i +: 32]));
        ua[i] = (a[i] < 0) ? longint'(-a[i]) : a[i];
        if (ua[i] > m) m = ua[i];
      end
      res.axis_zero = (m == 0);
      res.saturated = 0;
      if (m == 0) begin
        for (int i = 0; i < 3; i++) r[i] = v[i];
      end else begin
        // Normalise the axis
        while (m < (64'd1 << 30)) begin
          m  = m << 1;
          sh = sh + 1;
        end
        for (int i = 0; i < 3; i++) begin
          ua[i] = ua[i] << sh;
          sum   = sum + ua[i] * ua[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
          e[i] = longint'((ua[i] << IFRAC) / len);
          if (a[i] < 0) e[i] = -e[i];
        end
        th = longint'($signed(d[210:192])) * (longint'(1) <<< (IFRAC - FRAC_BITS));
        sin_cos(th, s, c);
        omc  = (longint'(1) <<< IFRAC) - c;
        k[0] = rnd30(e[1] * v[2] - e[2] * v[1]);
        k[1] = rnd30(e[2] * v[0] - e[0] * v[2]);
        k[2] = rnd30(e[0] * v[1] - e[1] * v[0]);
        w[0] = rnd30(e[1] * k[2] - e[2] * k[1]);
        w[1] = rnd30(e[2] * k[0] - e[0] * k[2]);
        w[2] = rnd30(e[0] * k[1] - e[1] * k[0]);
        for (int i = 0; i < 3; i++) r[i] = v[i] + rnd30(s * k[i]) + rnd30(omc * w[i]);
      end
      // Clip to the component range
      for (int i = 0; i < 3; i++) begin
        if (r[i] > 64'sd2147483647) begin
          r[i] = 64'sd2147483647;
          res.saturated = 1;
        end else if (r[i] < -64'sd2147483648) begin
          r[i] = -64'sd2147483648;
          res.saturated = 1;
        end
      end
      res.rot_x = r[0][31:0];
      res.rot_y = r[1][31:0];
      res.rot_z = r[2][31:0];
      return res;
    endfunction

    function void note_request(logic [215:0] d);
      pending_q.push_back(rotate(d));
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] user);
      rotation_t exp_r;
      bit        bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h user %b", data, user);
        return;
      end
      exp_r = pending_q.pop_front();
      bad   = (data[31:0] !== exp_r.rot_x) || (data[63:32] !== exp_r.rot_y) ||
              (data[95:64] !== exp_r.rot_z) || (user[0] !== exp_r.axis_zero) ||
              (user[1] !== exp_r.saturated);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: exp x=%h y=%h z=%h zero=%b sat=%b, ",
                    "got x=%h y=%h z=%h zero=%b sat=%b"},
                   exp_r.rot_x, exp_r.rot_y, exp_r.rot_z, exp_r.axis_zero, exp_r.saturated,
                   data[31:0], data[63:32], data[95:64], user[0], user[1]);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_valid;
  logic         s_axis_tready;
  logic [215:0] s_data;
  logic         m_axis_tvalid;
  logic         m_ready;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  rotation_scoreboard sb;
  bit idle_on;
  bit hold_req;

  rodrigues_vector_rotation #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_axis_tready) sb.note_request(s_data);
    if (rst_ni && m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Drive the result ready: random idling, or a long hold when requested
  initial begin
    int held;
    m_ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_ready <= !(idle_on && $urandom_range(99) < 17);
        @(posedge clk_i);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic [18:0] ang);
    while (idle_on && $urandom_range(99) < 17) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {5'b0, ang, az, ay, ax, vz, vy, vx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Random component: full range, small, or a boundary value
  function automatic logic [31:0] rand_comp();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom();
    if (sel < 8) return $unsigned(int'($urandom_range(131072)) - 65536);
    if (sel == 8) return 32'h7fffffff;
    return 32'h80000000;
  endfunction

  function automatic logic [18:0] rand_angle();
    if ($urandom_range(9) == 0) return 19'($urandom());
    return 19'(int'($urandom_range(411774)) - 205887);
  endfunction

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Overall time limit
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [31:0] ax, ay, az;
    sb       = new();
    idle_on  = 1;
    hold_req = 0;
    rst_ni   = 1'b0;
    s_valid  = 1'b0;
    s_data   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero axis, boundary angles, extreme vectors, axis directions
    send_request(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 19'd65536);
    send_request(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 19'd0);
    send_request(32'h00010000, 0, 0, 0, 0, 32'h00010000, 19'd102944);
    send_request(32'h00010000, 0, 0, 0, 0, 32'h00010000, 19'd205887);
    send_request(32'h00010000, 0, 0, 0, 0, 32'h00010000, -19'sd205887);
    send_request(32'h00010000, 32'h00010000, 0, 0, 0, 32'h00000001, 19'h3ffff);
    send_request(32'h00010000, 32'h00010000, 0, 0, 0, 32'hffffffff, 19'h40000);
    send_request(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00010000, 0, 0, 19'd154416);
    send_request(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, -19'sd154416);
    send_request(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 19'd205887);
    send_request(32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000, 0, 19'd51472);
    send_request(0, 0, 0, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 19'd1);
    send_request(32'hffffffff, 32'h00000001, 32'hffffffff, 32'h00000003, 32'h00000004,
                 0, -19'sd1);
    send_request(32'h00030000, 32'hfffd0000, 32'h00050000, 32'h7fffffff, 0, 32'h00000001,
                 19'd0);

    // Random requests with one long result hold, a drained pause and a no-idle stretch
    for (int n = 0; n < 500; n++) begin
      if (n == 100) hold_req = 1;
      if (n == 250) wait_drained();
      idle_on = !(n >= 300 && n < 400);
      if ($urandom_range(19) == 0) begin
        ax = 0;
        ay = 0;
        az = 0;
      end else begin
        ax = rand_comp();
        ay = ($urandom_range(4) == 0) ? 32'h0 : rand_comp();
        az = rand_comp();
      end
      send_request(rand_comp(), rand_comp(), rand_comp(), ax, ay, az, rand_angle());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
